@@ rtl/core/xip_cache_window_fit_macros.svh @@
// Assertion macros for the cache window fitter.
// Included by the top level; no other dependencies.
`ifndef XIP_CACHE_WINDOW_FIT_MACROS_SVH
`define XIP_CACHE_WINDOW_FIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define XCWF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xcwf same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define XCWF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xcwf next-cycle check failed");

`endif

@@ rtl/core/xcwf_pkg.sv @@
// Shared types and constants for the cache window fitter.
// No dependencies; used by every module of the block.
package xcwf_pkg;

    localparam int unsigned MinWinLog2 = 12;
    localparam int unsigned MaxWinLog2 = 31;
    localparam int unsigned Steps      = MaxWinLog2 - MinWinLog2 + 1;
    localparam int unsigned StepIdxW   = $clog2(Steps);
    localparam logic [31:0] MinWindow  = 32'd4096;
    localparam logic [31:0] BudgetRst  = 32'd262144;
    localparam int unsigned NumStages  = 7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FAMILY    = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_NO_BUDGET = 2'd3
    } t_status;

    // Hand-off from the window search to the placement stages.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] region_end;
        logic [31:0] wbase_dn;
        logic [31:0] wsz;
        t_status     status;
    } t_search_out;

    // Final result held in the output stage.
    typedef struct packed {
        logic [31:0] window_base;
        logic [31:0] window_size;
        logic        limited;
        t_status     status;
    } t_fit_out;

endpackage

@@ rtl/core/xcwf_search.sv @@
// Window size search: budget room, parallel doubling checks, first-stop encode.
// Depends on xcwf_pkg. Stages 1 to 3 of the pipeline.
module xcwf_search (
    input  logic                 i_clk,
    input  logic [2:0]           i_en,
    input  logic [31:0]          i_budget,
    input  logic [31:0]          i_region_base,
    input  logic [31:0]          i_region_size,
    input  logic [31:0]          i_cache_in_use,
    input  logic                 i_family_excluded,
    input  logic                 i_free_slot_present,
    output xcwf_pkg::t_search_out o_res
);

    // Stage 1 registers
    logic [31:0] r1_base, r1_end, r1_room;
    logic        r1_fam, r1_slot;
    // Stage 2 registers
    logic [31:0] r2_base, r2_end;
    logic [xcwf_pkg::Steps-1:0] r2_stop;
    xcwf_pkg::t_status r2_status;
    // Stage 3 registers
    xcwf_pkg::t_search_out r3_res;

    logic [32:0] n1_diff;
    logic [xcwf_pkg::Steps-1:0] n2_stop;
    xcwf_pkg::t_status n2_status;
    logic [xcwf_pkg::StepIdxW-1:0] n3_idx;
    logic [31:0] n3_wsz;

    // Room left in the budget, zero when the cache in use already exceeds it.
    assign n1_diff = {1'b0, i_budget} - {1'b0, i_cache_in_use};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_base <= i_region_base;
            r1_end  <= i_region_base + i_region_size;
            r1_room <= n1_diff[32] ? 32'd0 : n1_diff[31:0];
            r1_fam  <= i_family_excluded;
            r1_slot <= i_free_slot_present;
        end
    end

    // Every candidate size is checked at once: the search stops at a size when
    // its aligned-down window reaches the end, or when the doubled size does
    // not fit the remaining room.
    always_comb begin
        logic [31:0] sz;
        logic [31:0] wend;
        logic [32:0] dbl;
        n2_stop = '0;
        for (int j = 0; j < xcwf_pkg::Steps; j++) begin
            sz   = 32'(64'd1 << (xcwf_pkg::MinWinLog2 + j));
            wend = (r1_base & ~(sz - 32'd1)) + sz;
            dbl  = 33'(64'd1 << (xcwf_pkg::MinWinLog2 + j + 1));
            n2_stop[j] = (wend >= r1_end) || ({1'b0, r1_room} < dbl);
        end
    end

    always_comb begin
        if (r1_fam) begin
            n2_status = xcwf_pkg::ST_FAMILY;
        end else if (!r1_slot) begin
            n2_status = xcwf_pkg::ST_NO_SLOT;
        end else if (r1_room < xcwf_pkg::MinWindow) begin
            n2_status = xcwf_pkg::ST_NO_BUDGET;
        end else begin
            n2_status = xcwf_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_base   <= r1_base;
            r2_end    <= r1_end;
            r2_stop   <= n2_stop;
            r2_status <= n2_status;
        end
    end

    // The largest size can never fit twice over, so some stop bit is always set.
    always_comb begin
        n3_idx = '0;
        for (int j = xcwf_pkg::Steps - 1; j >= 0; j--) begin
            if (r2_stop[j]) begin
                n3_idx = xcwf_pkg::StepIdxW'(j);
            end
        end
        n3_wsz = 32'd1 << (6'(xcwf_pkg::MinWinLog2) + 6'(n3_idx));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_res.base       <= r2_base;
            r3_res.region_end <= r2_end;
            r3_res.wsz        <= n3_wsz;
            r3_res.wbase_dn   <= r2_base & ~(n3_wsz - 32'd1);
            r3_res.status     <= r2_status;
        end
    end

    assign o_res = r3_res;

endmodule

@@ rtl/core/xcwf_place.sv @@
// Window placement: coverage of the aligned-down and aligned-up windows.
// Depends on xcwf_pkg. Stages 4 to 7 of the pipeline.
module xcwf_place (
    input  logic                  i_clk,
    input  logic [3:0]            i_en,
    input  xcwf_pkg::t_search_out i_srch,
    output xcwf_pkg::t_fit_out    o_fit
);

    // Stage 4
    logic [31:0] r4_base, r4_end, r4_wbase, r4_wsz, r4_wend, r4_alt;
    xcwf_pkg::t_status r4_status;
    // Stage 5
    logic [31:0] r5_end, r5_wbase, r5_wsz, r5_alt, r5_alt_end, r5_low_cov;
    logic        r5_lim;
    xcwf_pkg::t_status r5_status;
    // Stage 6
    logic [31:0] r6_wbase, r6_wsz, r6_alt, r6_low_cov, r6_up_cov;
    logic        r6_lim;
    xcwf_pkg::t_status r6_status;
    // Stage 7
    xcwf_pkg::t_fit_out r7_fit;

    logic [31:0] n4_wend;
    logic        n7_up;
    logic        n7_ok;

    assign n4_wend = i_srch.wbase_dn + i_srch.wsz;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_base   <= i_srch.base;
            r4_end    <= i_srch.region_end;
            r4_wbase  <= i_srch.wbase_dn;
            r4_wsz    <= i_srch.wsz;
            r4_wend   <= n4_wend;
            // Aligning up lands on the next window unless the base is aligned.
            r4_alt    <= (i_srch.wbase_dn == i_srch.base) ? i_srch.base : n4_wend;
            r4_status <= i_srch.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r5_end     <= r4_end;
            r5_wbase   <= r4_wbase;
            r5_wsz     <= r4_wsz;
            r5_alt     <= r4_alt;
            r5_alt_end <= r4_alt + r4_wsz;
            r5_low_cov <= r4_wend - r4_base;
            r5_lim     <= r4_wend < r4_end;
            r5_status  <= r4_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r6_wbase   <= r5_wbase;
            r6_wsz     <= r5_wsz;
            r6_alt     <= r5_alt;
            r6_low_cov <= r5_low_cov;
            r6_up_cov  <= ((r5_alt_end < r5_end) ? r5_alt_end : r5_end) - r5_alt;
            r6_lim     <= r5_lim;
            r6_status  <= r5_status;
        end
    end

    assign n7_ok = (r6_status == xcwf_pkg::ST_OK);
    assign n7_up = r6_lim && (r6_up_cov > r6_low_cov);

    // A refused request reports zeros in every field but the status.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r7_fit.window_base <= !n7_ok ? 32'd0 : (n7_up ? r6_alt : r6_wbase);
            r7_fit.window_size <= n7_ok ? r6_wsz : 32'd0;
            r7_fit.limited     <= n7_ok && r6_lim;
            r7_fit.status      <= r6_status;
        end
    end

    assign o_fit = r7_fit;

endmodule

@@ rtl/core/xip_cache_window_fit.sv @@
// Cache window fitter: a request passes through search stages 1 to 3 and placement stages 4 to 7.
// Throughput is one request per cycle; the seven register stages advance
// independently, so a stage only holds while the stage after it is full and stalled.
// Synchronous active-low reset clears the stage valid bits and sets the cache
// budget to 256 KiB; payload registers are not reset.
// Depends on xcwf_pkg, xcwf_search, xcwf_place and the macro header.
`include "xip_cache_window_fit_macros.svh"

module xip_cache_window_fit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cache budget in bytes
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // Request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_region_base,
    input  logic [31:0] i_region_size,
    input  logic [31:0] i_cache_in_use,
    input  logic        i_family_excluded,
    input  logic        i_free_slot_present,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_window_base,
    output logic [31:0] o_window_size,
    output logic        o_limited,
    output logic [1:0]  o_status
);

    localparam int unsigned NStg = xcwf_pkg::NumStages;

    logic [31:0]     r_budget;
    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] n_en;

    xcwf_pkg::t_search_out srch;
    xcwf_pkg::t_fit_out    fit;

    // Terms used by the checks at the end of the module.
    logic chk_ok;
    logic chk_refused;
    logic chk_no_window;
    logic chk_size;
    logic chk_aligned;

    // The user must write the budget only while the pipeline is empty; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= xcwf_pkg::BudgetRst;
        end else if (i_cfg_we) begin
            r_budget <= i_cfg_wdata;
        end
    end

    // A stage may load when it is empty or when the stage after it loads
    // this cycle. The last stage frees up when the result request is taken.
    always_comb begin
        n_en[NStg-1] = !r_vld[NStg-1] || i_ready;
        for (int s = NStg - 2; s >= 0; s--) begin
            n_en[s] = !r_vld[s] || n_en[s+1];
        end
    end

    // Valid bits follow the data through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NStg; s++) begin
                if (n_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready = n_en[0];

    xcwf_search u_search (
        .i_clk               (i_clk),
        .i_en                (n_en[2:0]),
        .i_budget            (r_budget),
        .i_region_base       (i_region_base),
        .i_region_size       (i_region_size),
        .i_cache_in_use      (i_cache_in_use),
        .i_family_excluded   (i_family_excluded),
        .i_free_slot_present (i_free_slot_present),
        .o_res               (srch)
    );

    xcwf_place u_place (
        .i_clk  (i_clk),
        .i_en   (n_en[6:3]),
        .i_srch (srch),
        .o_fit  (fit)
    );

    assign o_valid       = r_vld[NStg-1];
    assign o_window_base = fit.window_base;
    assign o_window_size = fit.window_size;
    assign o_limited     = fit.limited;
    assign o_status      = fit.status;

    assign chk_ok        = o_valid && (o_status == xcwf_pkg::ST_OK);
    assign chk_refused   = o_valid && (o_status != xcwf_pkg::ST_OK);
    assign chk_no_window = (o_window_base == 32'd0) && (o_window_size == 32'd0) && !o_limited;
    assign chk_size      = $onehot(o_window_size) && (o_window_size >= xcwf_pkg::MinWindow);
    assign chk_aligned   = (o_window_base & (o_window_size - 32'd1)) == 32'd0;

    // A refused request carries no window.
    `XCWF_ASSERT_IMPLY(a_refused_zero, i_clk, i_rst_n, chk_refused, chk_no_window)
    // An accepted window is a power of two of at least the minimum size.
    `XCWF_ASSERT_IMPLY(a_size_pow2, i_clk, i_rst_n, chk_ok, chk_size)
    // An accepted window is naturally aligned to its size.
    `XCWF_ASSERT_IMPLY(a_aligned, i_clk, i_rst_n, chk_ok, chk_aligned)
    // A stalled result is not dropped.
    `XCWF_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

endmodule
